### src/rtfp_pkg.sv
`timescale 1ns / 1ps
package rtfp_pkg;

  localparam int SLOT_W     = 3;
  localparam int HDR_IDX_W  = 2;
  localparam int ROW_W      = 64;

  localparam logic [7:0] SYNC_BYTE   = 8'hAA;
  localparam logic [7:0] FOOT_LO     = 8'h55;
  localparam logic [7:0] FOOT_HI     = 8'hCC;
  localparam logic [7:0] MAG_HI_MASK = 8'h7F;
  localparam logic [7:0] SIGN_BIT    = 8'h80;
  localparam logic [14:0] SPEED_BAD_A = 15'd248;
  localparam logic [14:0] SPEED_BAD_B = 15'd256;
  localparam logic [HDR_IDX_W-1:0] HDR_LAST = 2'd3;

  typedef struct packed {
    logic                 take;
    logic [HDR_IDX_W-1:0] hdr_idx;
    logic                 wr_row;
    logic                 rd;
    logic                 load;
    logic                 clear_cnt;
    logic                 last;
    logic [SLOT_W-1:0]    slot;
  } ctl_cmd_t;

  typedef struct packed {
    logic hdr_hit;
    logic sync;
    logic foot_lo;
    logic foot_hi;
    logic out_free;
  } ctl_sts_t;

  function automatic logic [7:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = SYNC_BYTE;
      2'd1:    b = 8'hFF;
      2'd2:    b = 8'h03;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [14:0] sm_mag(input logic [7:0] lo, input logic [7:0] hi);
    logic [7:0] h;
    h = hi & MAG_HI_MASK;
    return {h[6:0], lo};
  endfunction

  function automatic logic signed [15:0] sm_decode(input logic [7:0] lo,
                                                   input logic [7:0] hi);
    logic [15:0] m;
    m = {1'b0, sm_mag(lo, hi)};
    if ((hi & SIGN_BIT) != 8'h00) return m;
    return 16'(-m);
  endfunction

endpackage

### src/rtfp_if.sv
`timescale 1ns / 1ps
interface rtfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface rtfp_target_if;
  logic               valid;
  logic               ready;
  logic [2:0]         target_index;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] speed;
  logic [15:0]        resolution;
  logic               speed_ok;
  logic               present;
  logic [3:0]         present_count;
  logic               any_present;
  logic               last;

  modport source (output valid, output target_index, output pos_x, output pos_y,
                  output speed, output resolution, output speed_ok, output present,
                  output present_count, output any_present, output last, input ready);
  modport sink (input valid, input target_index, input pos_x, input pos_y,
                input speed, input resolution, input speed_ok, input present,
                input present_count, input any_present, input last, output ready);
endinterface

### src/rtfp_datapath.sv
`timescale 1ns / 1ps
module rtfp_datapath #(
  parameter int TARGET_SLOTS = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          data_byte,
  input  rtfp_pkg::ctl_cmd_t  cmd,
  output rtfp_pkg::ctl_sts_t  sts,
  rtfp_target_if.source       targets
);
  import rtfp_pkg::*;

  localparam int AW = (TARGET_SLOTS > 1) ? $clog2(TARGET_SLOTS) : 1;

  logic [ROW_W-1:0] mem [TARGET_SLOTS];
  logic [ROW_W-9:0] row_buf;
  logic [ROW_W-1:0] rd_row;
  logic [3:0]       cnt;

  logic [14:0] mx, my, ms;
  logic        sok, pres;
  logic [3:0]  cnt_next;

  always_comb begin
    mx = sm_mag(rd_row[7:0], rd_row[15:8]);
    my = sm_mag(rd_row[23:16], rd_row[31:24]);
    ms = sm_mag(rd_row[55:48], rd_row[63:56]);
    sok = (ms != 15'd0) && (ms != SPEED_BAD_A) && (ms != SPEED_BAD_B);
    pres = ((mx != 15'd0) || (my != 15'd0)) && sok;
    cnt_next = cnt + {3'd0, pres};
  end

  assign sts.hdr_hit  = (data_byte == hdr_byte(cmd.hdr_idx));
  assign sts.sync     = (data_byte == SYNC_BYTE);
  assign sts.foot_lo  = (data_byte == FOOT_LO);
  assign sts.foot_hi  = (data_byte == FOOT_HI);
  assign sts.out_free = !targets.valid || targets.ready;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      row_buf <= {data_byte, row_buf[ROW_W-9:8]};
    end
    if (cmd.wr_row) begin
      mem[cmd.slot[AW-1:0]] <= {data_byte, row_buf};
    end
    if (cmd.rd) begin
      rd_row <= mem[cmd.slot[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      targets.valid <= 1'b0;
      cnt           <= 4'd0;
    end else begin
      if (cmd.clear_cnt) begin
        cnt <= 4'd0;
      end else if (cmd.load) begin
        cnt <= cnt_next;
      end
      if (cmd.load) begin
        targets.valid <= 1'b1;
      end else if (targets.ready) begin
        targets.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      targets.target_index  <= cmd.slot;
      targets.pos_x         <= sm_decode(rd_row[7:0], rd_row[15:8]);
      targets.pos_y         <= sm_decode(rd_row[23:16], rd_row[31:24]);
      targets.speed         <= sm_decode(rd_row[55:48], rd_row[63:56]);
      targets.resolution    <= rd_row[47:32];
      targets.speed_ok      <= sok;
      targets.present       <= pres;
      targets.present_count <= cmd.last ? cnt_next : 4'd0;
      targets.any_present   <= cmd.last && (cnt_next != 4'd0);
      targets.last          <= cmd.last;
    end
  end

endmodule

### src/rtfp_ctrl.sv
`timescale 1ns / 1ps
module rtfp_ctrl #(
  parameter int TARGET_SLOTS = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rtfp_pkg::ctl_sts_t sts,
  output rtfp_pkg::ctl_cmd_t cmd
);
  import rtfp_pkg::*;

  localparam logic [2:0] S_HDR   = 3'd0;
  localparam logic [2:0] S_BODY  = 3'd1;
  localparam logic [2:0] S_FOOT  = 3'd2;
  localparam logic [2:0] S_CLOSE = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TARGET_SLOTS - 1);

  logic [2:0]           state, state_next;
  logic [HDR_IDX_W-1:0] hdr_idx, hdr_idx_next;
  logic [2:0]           bidx, bidx_next;
  logic [SLOT_W-1:0]    slot, slot_next;
  logic                 foot_ok, foot_ok_next;
  logic                 take;

  always_comb begin
    in_ready     = state inside {S_HDR, S_BODY, S_FOOT, S_CLOSE};
    take         = in_valid && in_ready;
    state_next   = state;
    hdr_idx_next = hdr_idx;
    bidx_next    = bidx;
    slot_next    = slot;
    foot_ok_next = foot_ok;
    cmd          = '0;
    cmd.take     = take;
    cmd.hdr_idx  = hdr_idx;
    cmd.slot     = slot;
    case (state)
      S_HDR: begin
        if (take) begin
          if (sts.hdr_hit) begin
            if (hdr_idx == HDR_LAST) begin
              state_next   = S_BODY;
              hdr_idx_next = '0;
              bidx_next    = '0;
              slot_next    = '0;
            end else begin
              hdr_idx_next = hdr_idx + 1'b1;
            end
          end else begin
            hdr_idx_next = sts.sync ? HDR_IDX_W'(1) : '0;
          end
        end
      end
      S_BODY: begin
        if (take) begin
          bidx_next = bidx + 1'b1;
          if (bidx == 3'd7) begin
            cmd.wr_row = 1'b1;
            if (slot == LAST_SLOT) begin
              state_next = S_FOOT;
            end else begin
              slot_next = slot + 1'b1;
            end
          end
        end
      end
      S_FOOT: begin
        if (take) begin
          foot_ok_next = sts.foot_lo;
          state_next   = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (take) begin
          if (foot_ok && sts.foot_hi) begin
            cmd.clear_cnt = 1'b1;
            slot_next     = '0;
            state_next    = S_READ;
          end else begin
            state_next = S_HDR;
          end
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          cmd.last = (slot == LAST_SLOT);
          if (slot == LAST_SLOT) begin
            state_next = S_HDR;
          end else begin
            slot_next  = slot + 1'b1;
            state_next = S_READ;
          end
        end
      end
      default: begin
        state_next = S_HDR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_HDR;
      hdr_idx <= '0;
      bidx    <= '0;
      slot    <= '0;
      foot_ok <= 1'b0;
    end else begin
      state   <= state_next;
      hdr_idx <= hdr_idx_next;
      bidx    <= bidx_next;
      slot    <= slot_next;
      foot_ok <= foot_ok_next;
    end
  end

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> sts.out_free)
    else $error("result loaded while output register full");

  a_read_then_emit: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> state == S_EMIT)
    else $error("row read not followed by emit");

  a_row_write_in_body: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_row |-> (take && state == S_BODY && bidx == 3'd7))
    else $error("row write outside target body");

  a_last_returns_to_hunt: assert property (@(posedge clk) disable iff (rst)
    cmd.load && cmd.last |=> state == S_HDR)
    else $error("final result did not restart the header hunt");

endmodule

### src/radar_target_frame_parser_core.sv
`timescale 1ns / 1ps
// Radar target frame parser.
// stream: one serial byte per transfer. targets: one decoded target per
// transfer, TARGET_SLOTS transfers for each frame with a good footer.
// The parser hunts for the header AA FF 03 00, stores each 8-byte target as
// one row of a TARGET_SLOTS-deep memory, then checks the footer 55 CC.
// Header, body and footer bytes are taken while stream.ready is high. After a
// good closing byte, stream.ready drops while the results go out: each slot
// reads its row (S_READ), then loads the output register (S_EMIT). The first
// result is valid once the first slot has passed through S_READ and S_EMIT
// and loaded the output register. A row read and its load never overlap.
// The last result may wait in the output register while the next frame's
// bytes are taken. If targets stalls, emission pauses and stream.ready stays
// low until room frees up. A bad footer emits nothing.
// Reset (rst, synchronous) returns the parser to the header hunt and empties
// the output register; the target memory is not cleared.
module radar_target_frame_parser_core #(
  parameter int TARGET_SLOTS = 3
) (
  input  logic          clk,
  input  logic          rst,
  rtfp_byte_if.sink     stream,
  rtfp_target_if.source targets
);
  import rtfp_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;
  logic     in_ready;

  assign stream.ready = in_ready;

  rtfp_ctrl #(
    .TARGET_SLOTS (TARGET_SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stream.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rtfp_datapath #(
    .TARGET_SLOTS (TARGET_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .data_byte (stream.data_byte),
    .cmd       (cmd),
    .sts       (sts),
    .targets   (targets)
  );

endmodule
